// ----- rtl/pfw_pkg.sv -----
// ----------------------------------------------------------------------------
// pfw_pkg: shared types and constants for the page frame buffer pixel writer
// Holds command and result types, opcodes and default geometry.
// ----------------------------------------------------------------------------
package pfw_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // input item kinds (in_tuser)
  localparam logic [1:0] KIND_DRAW  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_TAKE  = 2'd3;

  // rotation register codes
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_90   = 2'd1;
  localparam logic [1:0] ROT_180  = 2'd2;
  localparam logic [1:0] ROT_270  = 2'd3;

  typedef enum logic [2:0] {
    OP_DRAW,    // read-modify-write one byte
    OP_CLEAR,   // sweep the store
    OP_READ,    // return one byte
    OP_TAKE,    // report box, drop pending
    OP_REPORT   // no store access, report box
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] col;
    logic [2:0] page;
    logic [2:0] bit_sel;
    logic       color;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       window_pending;
    logic [6:0] window_min_x;
    logic [6:0] window_max_x;
    logic [2:0] window_min_page;
    logic [2:0] window_max_page;
  } res_t;

endpackage

// ----- rtl/page_framebuffer_pixel_writer.sv -----
// ----------------------------------------------------------------------------
// page_framebuffer_pixel_writer: monochrome page frame buffer with dirty box
// Front stage rotates and classifies beats, a short queue decouples it from
// the back stage that owns the store, the dirty box and the result register.
//
//   channel | dir | tdata (low bit first)                      | tuser
//   in_     | in  | pos_x, pos_y, color, read_page, read_column | kind
//   out_    | out | read_data, window_pending, window_min_x,   | -
//           |     | window_max_x, window_min_page, max_page    |
//   cfg_    | in  | cfg_wr_data = rotation, written on wr_en   | -
//
// Steps: a draw reads the store, then writes the byte back; a read returns
// the registered store byte; take-dirty, off-screen draws and out-of-range
// reads load the result in their pop cycle; a clear sweeps the whole store.
// Reset: synchronous; afterwards a zeroing sweep of all PAGES*SCREEN_WIDTH
// bytes (1024 at 128x64) holds in_tready low.
// Stalls: the queue keeps accepting while the back stage works or while a
// result waits in the output register for out_tready, until its
// QUEUE_DEPTH entries are full.
// ----------------------------------------------------------------------------
module page_framebuffer_pixel_writer #(
  parameter int SCREEN_WIDTH  = pfw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfw_pkg::SCREEN_HEIGHT_DEF,
  parameter int QUEUE_DEPTH   = pfw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,   // rotation
  input  logic        in_tvalid,
  output logic        in_tready,
  // pos_x[7:0], pos_y[15:8], color[16], read_page[19:17], read_column[26:20]
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,      // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0], window_pending[8], window_min_x[15:9], window_max_x[22:16],
  // window_min_page[25:23], window_max_page[28:26]
  output logic [31:0] out_tdata
);

  logic          push, q_full, q_valid, pop, init_busy;
  pfw_pkg::cmd_t push_cmd, q_cmd;
  pfw_pkg::res_t res;

  pfw_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_kind        (in_tuser),
    .in_pos_x       (in_tdata[7:0]),
    .in_pos_y       (in_tdata[15:8]),
    .in_color       (in_tdata[16]),
    .in_read_page   (in_tdata[19:17]),
    .in_read_column (in_tdata[26:20]),
    .q_full         (q_full),
    .init_busy      (init_busy),
    .push           (push),
    .cmd            (push_cmd)
  );

  pfw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_cmd),
    .full  (q_full),
    .pop   (pop),
    .dout  (q_cmd),
    .valid (q_valid)
  );

  pfw_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .init_busy (init_busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // unused upper bits tied to zero
  assign out_tdata = {3'd0, res.window_max_page, res.window_min_page,
                      res.window_max_x, res.window_min_x,
                      res.window_pending, res.read_data};

endmodule

// ----- rtl/pfw_front.sv -----
// ----------------------------------------------------------------------------
// pfw_front: input stage
// Holds the rotation register, rotates and range checks each beat and
// pushes a decoded command into the queue.
// ----------------------------------------------------------------------------
module pfw_front #(
  parameter int SCREEN_WIDTH  = pfw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_wr_data,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [1:0]    in_kind,
  input  logic [7:0]    in_pos_x,
  input  logic [7:0]    in_pos_y,
  input  logic          in_color,
  input  logic [2:0]    in_read_page,
  input  logic [6:0]    in_read_column,
  input  logic          q_full,
  input  logic          init_busy,
  output logic          push,
  output pfw_pkg::cmd_t cmd
);

  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;

  logic [1:0] rot_r;
  logic [8:0] x9, y9, tx, ty;
  logic       on_raw, on_rot, rd_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r <= pfw_pkg::ROT_NONE;
    end else if (cfg_wr_en) begin
      rot_r <= cfg_wr_data;
    end
  end

  assign x9 = {1'b0, in_pos_x};
  assign y9 = {1'b0, in_pos_y};
  assign on_raw = (x9 < 9'(SCREEN_WIDTH)) && (y9 < 9'(SCREEN_HEIGHT));

  always_comb begin
    case (rot_r)
      pfw_pkg::ROT_90: begin
        tx = 9'(SCREEN_HEIGHT - 1) - y9;
        ty = x9;
      end
      pfw_pkg::ROT_180: begin
        tx = 9'(SCREEN_WIDTH - 1) - x9;
        ty = 9'(SCREEN_HEIGHT - 1) - y9;
      end
      pfw_pkg::ROT_270: begin
        tx = y9;
        ty = 9'(SCREEN_WIDTH - 1) - x9;
      end
      default: begin
        tx = x9;
        ty = y9;
      end
    endcase
  end

  // non-square screens can rotate a valid point off the edge
  assign on_rot = (tx < 9'(SCREEN_WIDTH)) && (ty < 9'(SCREEN_HEIGHT));
  assign rd_ok  = ({1'b0, in_read_page} < 4'(PAGES)) &&
                  ({1'b0, in_read_column} < 8'(SCREEN_WIDTH));

  assign in_tready = !init_busy && !q_full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    cmd.col     = tx[6:0];
    cmd.page    = ty[5:3];
    cmd.bit_sel = ty[2:0];
    cmd.color   = in_color;
    case (in_kind)
      pfw_pkg::KIND_DRAW: begin
        cmd.op = (on_raw && on_rot) ? pfw_pkg::OP_DRAW : pfw_pkg::OP_REPORT;
      end
      pfw_pkg::KIND_CLEAR: begin
        cmd.op = pfw_pkg::OP_CLEAR;
      end
      pfw_pkg::KIND_READ: begin
        cmd.op   = rd_ok ? pfw_pkg::OP_READ : pfw_pkg::OP_REPORT;
        cmd.col  = in_read_column;
        cmd.page = in_read_page;
      end
      pfw_pkg::KIND_TAKE: begin
        cmd.op = pfw_pkg::OP_TAKE;
      end
      default: begin
        cmd.op = pfw_pkg::OP_REPORT;
      end
    endcase
  end

endmodule

// ----- rtl/pfw_fifo.sv -----
// ----------------------------------------------------------------------------
// pfw_fifo: command queue
// Small register FIFO between the front and back stages.
// ----------------------------------------------------------------------------
module pfw_fifo #(
  parameter int DEPTH = pfw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pfw_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output pfw_pkg::cmd_t dout,
  output logic          valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pfw_pkg::cmd_t    ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/pfw_back.sv -----
// ----------------------------------------------------------------------------
// pfw_back: execution stage
// Owns the page store, the dirty box and the output register. Runs draws
// as read-modify-write, sweeps the store on clear and after reset.
// ----------------------------------------------------------------------------
module pfw_back #(
  parameter int SCREEN_WIDTH  = pfw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  pfw_pkg::cmd_t q_cmd,
  output logic          pop,
  output logic          init_busy,
  output logic          out_valid,
  input  logic          out_ready,
  output pfw_pkg::res_t out_res
);

  localparam int PAGES  = (SCREEN_HEIGHT + 7) / 8;
  localparam int DEPTH  = PAGES * SCREEN_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_DRAW, S_READ, S_CLEAR} state_t;

  state_t             state_r;
  pfw_pkg::cmd_t      cmd_r;
  logic [ADDR_W-1:0]  addr_r, clr_cnt_r, cmd_addr;
  logic               clr_item_r;
  logic               out_valid_r;
  logic               out_load;
  pfw_pkg::res_t      res_r;
  logic               pending_r;
  logic [6:0]         left_r, right_r;
  logic [2:0]         top_r, bottom_r;
  logic [6:0]         left_nxt, right_nxt;
  logic [2:0]         top_nxt, bottom_nxt;
  logic [7:0]         mem_r [DEPTH];
  logic [7:0]         rd_data_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [7:0]         mem_wd, bit_mask;

  assign cmd_addr  = ADDR_W'(int'(q_cmd.page) * SCREEN_WIDTH + int'(q_cmd.col));
  assign pop       = (state_r == S_IDLE) && q_valid && (!out_valid_r || out_ready);
  assign init_busy = (state_r == S_CLEAR) && !clr_item_r;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign bit_mask  = 8'd1 << cmd_r.bit_sel;

  // take-dirty and report-only beats load the result in their pop cycle
  assign out_load  = pop && (q_cmd.op != pfw_pkg::OP_DRAW) &&
                     (q_cmd.op != pfw_pkg::OP_READ) && (q_cmd.op != pfw_pkg::OP_CLEAR);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = cmd_r.color ? (rd_data_r | bit_mask) : (rd_data_r & ~bit_mask);
    case (state_r)
      S_DRAW: begin
        mem_we = 1'b1;
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = '0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem_r[cmd_addr];
  end

  // box after a draw; a fresh box starts when nothing is pending
  always_comb begin
    if (!pending_r) begin
      left_nxt   = cmd_r.col;
      right_nxt  = cmd_r.col;
      top_nxt    = cmd_r.page;
      bottom_nxt = cmd_r.page;
    end else begin
      left_nxt   = (cmd_r.col < left_r) ? cmd_r.col : left_r;
      right_nxt  = (cmd_r.col > right_r) ? cmd_r.col : right_r;
      top_nxt    = (cmd_r.page < top_r) ? cmd_r.page : top_r;
      bottom_nxt = (cmd_r.page > bottom_r) ? cmd_r.page : bottom_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_item_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pending_r   <= 1'b1;
      left_r      <= '0;
      right_r     <= 7'(SCREEN_WIDTH - 1);
      top_r       <= '0;
      bottom_r    <= 3'(PAGES - 1);
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            cmd_r  <= q_cmd;
            addr_r <= cmd_addr;
            case (q_cmd.op)
              pfw_pkg::OP_DRAW: begin
                state_r <= S_DRAW;
              end
              pfw_pkg::OP_READ: begin
                state_r <= S_READ;
              end
              pfw_pkg::OP_CLEAR: begin
                pending_r  <= 1'b1;
                left_r     <= '0;
                right_r    <= 7'(SCREEN_WIDTH - 1);
                top_r      <= '0;
                bottom_r   <= 3'(PAGES - 1);
                clr_cnt_r  <= '0;
                clr_item_r <= 1'b1;
                state_r    <= S_CLEAR;
              end
              pfw_pkg::OP_TAKE: begin
                out_valid_r <= 1'b1;
                res_r       <= {8'd0, pending_r, left_r, right_r, top_r, bottom_r};
                pending_r   <= 1'b0;
              end
              default: begin
                out_valid_r <= 1'b1;
                res_r       <= {8'd0, pending_r, left_r, right_r, top_r, bottom_r};
              end
            endcase
          end
        end
        S_DRAW: begin
          pending_r   <= 1'b1;
          left_r      <= left_nxt;
          right_r     <= right_nxt;
          top_r       <= top_nxt;
          bottom_r    <= bottom_nxt;
          out_valid_r <= 1'b1;
          res_r       <= {8'd0, 1'b1, left_nxt, right_nxt, top_nxt, bottom_nxt};
          state_r     <= S_IDLE;
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          res_r       <= {rd_data_r, pending_r, left_r, right_r, top_r, bottom_r};
          state_r     <= S_IDLE;
        end
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= S_IDLE;
            if (clr_item_r) begin
              out_valid_r <= 1'b1;
              res_r       <= {8'd0, pending_r, left_r, right_r, top_r, bottom_r};
              clr_item_r  <= 1'b0;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // write-back cycle only follows a pop that found the output slot free or being taken
  a_draw_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAW) |-> !out_valid_r)
    else $error("draw write-back with output slot occupied");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !pop)
    else $error("queue popped while back stage busy");

  a_take_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_cmd.op == pfw_pkg::OP_TAKE) |=> (!pending_r && out_valid_r))
    else $error("take-dirty did not drop pending or report");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (left_r <= right_r && top_r <= bottom_r))
    else $error("dirty box inverted");
`endif

endmodule
